>>> sv/prx_pkg.sv
package prx_pkg;

  localparam int COORD_W_DEF = 24;
  localparam int THICK_W     = 12;
  localparam logic [THICK_W-1:0] THICK_RESET = 12'd20;
  localparam int FRAC_W      = 8;
  // offset magnitude never exceeds thickness * 2^FRAC_W
  localparam int QUOT_W      = THICK_W + FRAC_W;
  localparam int MUL_MAX_W   = 32;
  // widest segment magnitude over the supported coordinate range
  localparam int MAG_W       = 33;
  // when either magnitude is at or above 2^SHIFT_BIT, both are halved before squaring
  localparam int SHIFT_BIT   = 31;

endpackage

>>> sv/prx_mul.sv
module prx_mul
  import prx_pkg::*;
#(
  parameter int W = MUL_MAX_W
) (
  input  logic           clk,
  input  logic           en,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [2*W-1:0] p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end

endmodule

>>> sv/prx_sqrt.sv
module prx_sqrt
  import prx_pkg::*;
#(
  parameter int RW = COORD_W_DEF + 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [2*RW-1:0] radicand,
  output logic            done,
  output logic [RW-1:0]   root
);

  localparam int CNTW = $clog2(RW + 1);

  logic [2*RW-1:0] rad;
  logic [RW:0]     rem;
  logic [CNTW-1:0] cnt;
  logic [RW+1:0]   r4;
  logic [RW+1:0]   trial;
  logic [RW+1:0]   diff;
  logic            ge;

  // bring down two radicand bits, try root*4+1
  assign r4    = {rem[RW-1:0], rad[2*RW-1 -: 2]};
  assign trial = {root, 2'b01};
  assign ge    = (r4 >= trial);
  assign diff  = r4 - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CNTW'(1));
      if (start) begin
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= CNTW'(RW);
      end else if (cnt != '0) begin
        rad  <= rad << 2;
        rem  <= ge ? diff[RW:0] : r4[RW:0];
        root <= {root[RW-2:0], ge};
        cnt  <= cnt - CNTW'(1);
      end
    end
  end

endmodule

>>> sv/prx_div.sv
module prx_div
  import prx_pkg::*;
#(
  parameter int NW = COORD_W_DEF + 1 + THICK_W + FRAC_W + 2,
  parameter int VW = COORD_W_DEF + 3,
  parameter int QW = QUOT_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [QW-1:0] quotient
);

  localparam int CNTW = $clog2(QW + 1);

  logic [VW-1:0]   rem;
  logic [QW-1:0]   dvd;
  logic [CNTW-1:0] cnt;
  logic [VW:0]     r2;
  logic [VW:0]     diff;
  logic            ge;

  assign r2       = {rem, dvd[QW-1]};
  assign ge       = (r2 >= {1'b0, divisor});
  assign diff     = r2 - {1'b0, divisor};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CNTW'(1));
      if (start) begin
        // the upper part is below the divisor since the quotient fits QW bits
        rem <= VW'(dividend >> QW);
        dvd <= dividend[QW-1:0];
        cnt <= CNTW'(QW);
      end else if (cnt != '0) begin
        rem <= ge ? diff[VW-1:0] : r2[VW-1:0];
        dvd <= {dvd[QW-2:0], ge};
        cnt <= cnt - CNTW'(1);
      end
    end
  end

endmodule

>>> sv/polyline_ribbon_extruder_top.sv
// Polyline ribbon extruder: points of a 2D polyline go in one transaction at a
// time (signed fixed point, 8 fraction bits); out come triangle-strip vertices,
// a left and a right vertex offset from the previous point by thickness pixels
// at right angles to the segment, and on the point flagged last the first pair
// again to close the ring, after which the block starts a fresh polyline.
// A first point only opens the polyline. Every later point is worked through
// one shared multiplier, a bit-serial square root (COORD_WIDTH+2 steps, 33 at
// most) and two bit-serial divisions (20 steps each); a zero-length segment
// skips the divisions. in_stall stays high for the whole of that work.
// Coordinates saturate to the signed COORD_WIDTH range. thickness may be
// rewritten only while the block is idle.
module polyline_ribbon_extruder_top
  import prx_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_W_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          thickness_wr,
  input  logic [THICK_W-1:0]            thickness,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic                          last_point,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] vertex_x,
  output logic signed [COORD_WIDTH-1:0] vertex_y,
  output logic                          last_vertex
);

  localparam int MW = COORD_WIDTH + 1;
  localparam int SW = (MW > MUL_MAX_W) ? MUL_MAX_W : MW;
  localparam int RW = SW + 1;
  localparam int PW = SW + THICK_W;
  localparam int NW = PW + FRAC_W + 2;
  localparam int VW = RW + 1;
  localparam int OW = QUOT_W + 1;
  localparam int EW = COORD_WIDTH + OW;

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_SUM, S_ROOT, S_MX, S_MY, S_DX, S_DY, S_DYW, S_EMIT
  } state_t;

  state_t state;

  logic [THICK_W-1:0]            thick;
  logic signed [COORD_WIDTH-1:0] prev_x, prev_y, cur_x, cur_y;
  logic signed [COORD_WIDTH-1:0] first_left_x, first_left_y;
  logic signed [COORD_WIDTH-1:0] first_right_x, first_right_y;
  logic                          have_prev, have_first, cur_last;
  logic [SW-1:0]                 ax, ay;
  logic                          neg_x, neg_y;
  logic [2*SW-1:0]               sq_x;
  logic [RW-1:0]                 len;
  logic signed [OW-1:0]          ox, oy;
  logic [1:0]                    vidx;

  logic signed [MW-1:0] dx, dy;
  logic [MW-1:0]        adx, ady;
  logic [MAG_W-1:0]     ex_x, ex_y;
  logic                 big;
  logic [SW-1:0]        ax_next, ay_next;

  logic            mul_en;
  logic [SW-1:0]   mul_a, mul_b;
  logic [2*SW-1:0] mul_p;

  logic            sq_start, sq_done;
  logic [2*RW-1:0] rad;
  logic [RW-1:0]   sq_root;

  logic              dv_start, dv_done;
  logic [NW-1:0]     dv_dividend;
  logic [QUOT_W-1:0] dv_q;
  logic signed [OW-1:0] q_s;

  logic signed [EW-1:0]          sum_x, sum_y;
  logic signed [COORD_WIDTH-1:0] nx, ny;
  logic                          nlast, emit_fire;

  function automatic logic signed [COORD_WIDTH-1:0] clamp(input logic signed [EW-1:0] v);
    logic [EW-COORD_WIDTH:0] hi;
    hi = v[EW-1:COORD_WIDTH-1];
    if ((&hi) || !(|hi)) begin
      return v[COORD_WIDTH-1:0];
    end else if (v[EW-1]) begin
      return {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
  endfunction

  // segment magnitudes, halved together when either is too wide to square
  assign dx      = MW'(point_x) - MW'(prev_x);
  assign dy      = MW'(point_y) - MW'(prev_y);
  assign adx     = dx[MW-1] ? MW'(-dx) : MW'(dx);
  assign ady     = dy[MW-1] ? MW'(-dy) : MW'(dy);
  assign ex_x    = MAG_W'(adx);
  assign ex_y    = MAG_W'(ady);
  assign big     = (|ex_x[MAG_W-1:SHIFT_BIT]) || (|ex_y[MAG_W-1:SHIFT_BIT]);
  assign ax_next = SW'(big ? (ex_x >> 1) : ex_x);
  assign ay_next = SW'(big ? (ex_y >> 1) : ex_y);

  assign in_stall = (state != S_IDLE);

  assign mul_en = (state == S_SQX) || (state == S_SQY) || (state == S_MX) || (state == S_MY);
  assign mul_a  = ((state == S_SQY) || (state == S_MY)) ? ay : ax;
  assign mul_b  = (state == S_SQX) ? ax :
                  (state == S_SQY) ? ay : SW'(thick);

  prx_mul #(.W(SW)) u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign sq_start = (state == S_SUM);
  assign rad      = (2*RW)'(sq_x) + (2*RW)'(mul_p);

  prx_sqrt #(.RW(RW)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (rad),
    .done     (sq_done),
    .root     (sq_root)
  );

  // round to nearest: (2*m*t*256 + len) / (2*len)
  assign dv_start    = (state == S_MY) || (state == S_DY);
  assign dv_dividend = NW'({mul_p[PW-1:0], {(FRAC_W+1){1'b0}}}) + NW'(len);

  prx_div #(.NW(NW), .VW(VW), .QW(QUOT_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (dv_dividend),
    .divisor  ({len, 1'b0}),
    .done     (dv_done),
    .quotient (dv_q)
  );

  assign q_s = $signed({1'b0, dv_q});

  // left takes (+oy, -ox), right takes (-oy, +ox)
  assign sum_x = EW'(prev_x) + (vidx[0] ? -EW'(oy) : EW'(oy));
  assign sum_y = EW'(prev_y) + (vidx[0] ? EW'(ox) : -EW'(ox));

  always_comb begin
    case (vidx)
      2'd2: begin
        nx = first_left_x;
        ny = first_left_y;
      end
      2'd3: begin
        nx = first_right_x;
        ny = first_right_y;
      end
      default: begin
        nx = clamp(sum_x);
        ny = clamp(sum_y);
      end
    endcase
  end

  assign nlast     = (vidx == 2'd3) || ((vidx == 2'd1) && !cur_last);
  assign emit_fire = (state == S_EMIT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      thick      <= THICK_RESET;
      have_prev  <= 1'b0;
      have_first <= 1'b0;
      out_valid  <= 1'b0;
      vidx       <= '0;
    end else begin
      if (thickness_wr) begin
        thick <= thickness;
      end
      if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (!have_prev) begin
              if (last_point) begin
                have_first <= 1'b0;
              end else begin
                prev_x    <= point_x;
                prev_y    <= point_y;
                have_prev <= 1'b1;
              end
            end else begin
              cur_x    <= point_x;
              cur_y    <= point_y;
              cur_last <= last_point;
              ax       <= ax_next;
              ay       <= ay_next;
              neg_x    <= dx[MW-1];
              neg_y    <= dy[MW-1];
              vidx     <= '0;
              state    <= S_SQX;
            end
          end
        end
        S_SQX: state <= S_SQY;
        S_SQY: begin
          sq_x  <= mul_p;
          state <= S_SUM;
        end
        S_SUM: state <= S_ROOT;
        S_ROOT: begin
          if (sq_done) begin
            if (sq_root == '0) begin
              // zero-length segment: no offset
              ox    <= '0;
              oy    <= '0;
              state <= S_EMIT;
            end else begin
              len   <= sq_root;
              state <= S_MX;
            end
          end
        end
        S_MX: state <= S_MY;
        S_MY: state <= S_DX;
        S_DX: begin
          if (dv_done) begin
            ox    <= neg_x ? -q_s : q_s;
            state <= S_DY;
          end
        end
        S_DY: state <= S_DYW;
        S_DYW: begin
          if (dv_done) begin
            oy    <= neg_y ? -q_s : q_s;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            out_valid   <= 1'b1;
            vertex_x    <= nx;
            vertex_y    <= ny;
            last_vertex <= nlast;
            vidx        <= vidx + 2'd1;
            if (!have_first) begin
              if (vidx == 2'd0) begin
                first_left_x <= nx;
                first_left_y <= ny;
              end else begin
                first_right_x <= nx;
                first_right_y <= ny;
                have_first    <= 1'b1;
              end
            end
            if (nlast) begin
              state <= S_IDLE;
              if (cur_last) begin
                // ring closed: drop the polyline
                have_prev  <= 1'b0;
                have_first <= 1'b0;
              end else begin
                prev_x <= cur_x;
                prev_y <= cur_y;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sim/testbench.sv
module testbench
  import prx_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = COORD_W_DEF;
  localparam longint COORD_MAX = (longint'(1) << (CW - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;
  localparam int RANDOM_POINTS = 410;
  localparam int SETTLE_CYCLES = 2 * (CW + 56);
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PRINT_LIMIT = 40;

  typedef struct {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          last;
  } vertex_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 thickness_wr = 1'b0;
  logic [THICK_W-1:0]   thickness = THICK_RESET;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [CW-1:0] point_x = '0;
  logic signed [CW-1:0] point_y = '0;
  logic                 last_point = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [CW-1:0] vertex_x;
  logic signed [CW-1:0] vertex_y;
  logic                 last_vertex;

  // predicted block state
  logic [THICK_W-1:0] half_width = THICK_RESET;
  longint             trail_x = 0;
  longint             trail_y = 0;
  bit                 trail_valid = 1'b0;
  longint             ring_lx = 0;
  longint             ring_ly = 0;
  longint             ring_rx = 0;
  longint             ring_ry = 0;
  bit                 ring_valid = 1'b0;

  vertex_t pending_vertices[$];
  int      mismatches = 0;
  int      quiet_cycles = 0;
  bit      tx_quiet = 1'b0;
  bit      rx_quiet = 1'b0;

  polyline_ribbon_extruder_top #(.COORD_WIDTH(CW)) uut (
    .clk         (clk),
    .rst         (rst),
    .thickness_wr(thickness_wr),
    .thickness   (thickness),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .point_x     (point_x),
    .point_y     (point_y),
    .last_point  (last_point),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .vertex_x    (vertex_x),
    .vertex_y    (vertex_y),
    .last_vertex (last_vertex)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("%0t mismatch: %s", $time, msg);
  endtask

  function automatic longint clamp_coord(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // thickness * 256 * mag / len, rounded half away from zero
  function automatic longint offset_of(longint unsigned mag, bit neg, longint unsigned len);
    longint unsigned num;
    longint unsigned q;
    if (len == 0) return 0;
    num = mag * half_width * 64'd256;
    q = (64'd2 * num + len) / (64'd2 * len);
    return neg ? -longint'(q) : longint'(q);
  endfunction

  task automatic push_vertex(longint x, longint y, bit last);
    vertex_t v;
    v.x = x[CW-1:0];
    v.y = y[CW-1:0];
    v.last = last;
    pending_vertices.push_back(v);
  endtask

  task automatic clear_polyline();
    trail_x = 0;
    trail_y = 0;
    trail_valid = 1'b0;
    ring_lx = 0;
    ring_ly = 0;
    ring_rx = 0;
    ring_ry = 0;
    ring_valid = 1'b0;
  endtask

  task automatic extrude_point(longint px, longint py, bit closing);
    longint dx, dy, ox, oy, lx, ly, rx, ry;
    longint unsigned ax, ay, len;
    if (!trail_valid) begin
      if (closing) begin
        clear_polyline();
      end else begin
        trail_x = px;
        trail_y = py;
        trail_valid = 1'b1;
      end
      return;
    end
    dx = px - trail_x;
    dy = py - trail_y;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (ax >= (64'd1 << SHIFT_BIT) || ay >= (64'd1 << SHIFT_BIT)) begin
      ax >>= 1;
      ay >>= 1;
    end
    len = root_floor(ax * ax + ay * ay);
    ox = offset_of(ax, dx < 0, len);
    oy = offset_of(ay, dy < 0, len);
    lx = clamp_coord(trail_x + oy);
    ly = clamp_coord(trail_y - ox);
    rx = clamp_coord(trail_x - oy);
    ry = clamp_coord(trail_y + ox);
    if (!ring_valid) begin
      ring_lx = lx;
      ring_ly = ly;
      ring_rx = rx;
      ring_ry = ry;
      ring_valid = 1'b1;
    end
    push_vertex(lx, ly, 1'b0);
    push_vertex(rx, ry, !closing);
    if (closing) begin
      // close the ring with the first pair, then start afresh
      push_vertex(ring_lx, ring_ly, 1'b0);
      push_vertex(ring_rx, ring_ry, 1'b1);
      clear_polyline();
    end else begin
      trail_x = px;
      trail_y = py;
    end
  endtask

  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_point(longint x, longint y, bit last);
    logic [CW-1:0] bx;
    logic [CW-1:0] by;
    int unsigned gap;
    bx = x[CW-1:0];
    by = y[CW-1:0];
    in_valid <= 1'b1;
    point_x <= bx;
    point_y <= by;
    last_point <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    extrude_point(longint'($signed(bx)), longint'($signed(by)), last);
    gap = pick_gap(tx_quiet);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every vertex is out and the block has gone quiet
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_thickness(logic [THICK_W-1:0] value);
    thickness_wr <= 1'b1;
    thickness <= value;
    @(posedge clk);
    thickness_wr <= 1'b0;
    half_width = value;
  endtask

  function automatic logic [THICK_W-1:0] pick_thickness();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return THICK_RESET;
      3: return THICK_W'(1);
      default: return THICK_W'($urandom_range(0, (1 << THICK_W) - 1));
    endcase
  endfunction

  function automatic longint extreme_coord();
    case ($urandom_range(0, 6))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return COORD_MIN + 1;
      3: return COORD_MAX - 1;
      4: return -1;
      5: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic longint small_step();
    if ($urandom_range(0, 7) == 0) return 0;
    return longint'($urandom_range(0, 40000)) - 20000;
  endfunction

  task automatic test_lone_point();
    send_point(100, -200, 1'b1);
    drain_and_settle();
  endtask

  // reset thickness, right angles, a diagonal and a repeated point
  task automatic test_square_path();
    send_point(0, 0, 1'b0);
    send_point(2560, 0, 1'b0);
    send_point(2560, 2560, 1'b0);
    send_point(2560, 2560, 1'b0);
    send_point(777, -1234, 1'b0);
    send_point(0, 2560, 1'b1);
    drain_and_settle();
  endtask

  task automatic test_extremes();
    load_thickness('1);
    send_point(COORD_MIN, COORD_MIN, 1'b0);
    send_point(COORD_MAX, COORD_MAX, 1'b0);
    send_point(COORD_MAX, COORD_MIN, 1'b0);
    send_point(0, 0, 1'b0);
    send_point(COORD_MIN, COORD_MAX, 1'b1);
    drain_and_settle();
    load_thickness('0);
    send_point(-1, -1, 1'b0);
    send_point(COORD_MAX, 0, 1'b1);
    drain_and_settle();
  endtask

  // later segments take the new width, the stored first pair keeps the old
  task automatic test_thickness_mid_polyline();
    load_thickness(THICK_W'(100));
    send_point(0, 0, 1'b0);
    send_point(5000, 3000, 1'b0);
    drain_and_settle();
    load_thickness(THICK_W'(7));
    send_point(1000, 9000, 1'b0);
    send_point(-4000, -4000, 1'b1);
    drain_and_settle();
    load_thickness(THICK_RESET);
  endtask

  task automatic test_random_polylines();
    int unsigned sent;
    int unsigned len;
    int unsigned mode;
    longint cx, cy;
    sent = 0;
    while (sent < RANDOM_POINTS) begin
      tx_quiet = ($urandom_range(0, 5) == 0);
      rx_quiet = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 5) == 0) begin
        drain_and_settle();
        load_thickness(pick_thickness());
      end
      mode = $urandom_range(0, 9);
      len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 10);
      cx = longint'($urandom);
      cy = longint'($urandom);
      for (int i = 0; i < len; i++) begin
        if (mode < 6) begin
          // local walk, now and then a repeated point
          if ($urandom_range(0, 9) != 0) begin
            cx += small_step();
            cy += small_step();
          end
        end else if (mode < 8) begin
          cx = longint'($urandom);
          cy = longint'($urandom);
        end else begin
          cx = extreme_coord();
          cy = extreme_coord();
        end
        if (i == len / 2 && i != 0 && $urandom_range(0, 11) == 0) begin
          drain_and_settle();
          load_thickness(pick_thickness());
        end
        send_point(cx, cy, i == len - 1);
        sent++;
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!rx_quiet && $urandom_range(0, 99) < 30) begin
        out_stall <= 1'b1;
        repeat (1 + pick_gap(1'b0)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_vertices
    vertex_t due;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (pending_vertices.size() == 0) begin
        report_mismatch($sformatf("vertex (%0d,%0d) with none pending", vertex_x, vertex_y));
      end else begin
        due = pending_vertices.pop_front();
        if (vertex_x !== due.x)
          report_mismatch($sformatf("vertex_x got %0d want %0d", vertex_x, $signed(due.x)));
        if (vertex_y !== due.y)
          report_mismatch($sformatf("vertex_y got %0d want %0d", vertex_y, $signed(due.y)));
        if (last_vertex !== due.last)
          report_mismatch($sformatf("last_vertex got %b want %b", last_vertex, due.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_lone_point();
    test_square_path();
    test_extremes();
    test_thickness_mid_polyline();
    test_random_polylines();
    drain_and_settle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> polyline_ribbon_extruder_top.f
sv/prx_pkg.sv
sv/prx_mul.sv
sv/prx_sqrt.sv
sv/prx_div.sv
sv/polyline_ribbon_extruder_top.sv
sim/testbench.sv
